[rtl/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, types and helpers of the ring step sequencer.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_STEPS_DEF      = 32;
  localparam int NUM_SIDES_DEF      = 2;
  localparam int RINGS_PER_SIDE_DEF = 3;

  localparam int NUM_STEP_REGS = 6;
  localparam int PATTERN_W     = 32;
  localparam int BIT_SEL_W     = 5;
  localparam int CV_DEPTH      = 32;
  localparam int CV_ADDR_W     = 5;
  localparam int CV_W          = 12;
  localparam int PITCH_W       = 4;
  localparam int DEST_W        = 3;
  localparam int FUNC_W        = 3;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 32;
  localparam int STEPS_REG_W   = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEPS0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEST   = 3'd6;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_TICK   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_STEP   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RING   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SIDE   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TOGGLE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CV     = 3'd5;

  localparam logic [STEPS_REG_W-1:0] STEPS_RESET [NUM_STEP_REGS] =
    '{6'd16, 6'd12, 6'd6, 6'd16, 6'd12, 6'd6};
  localparam logic [CFG_DATA_W-1:0] DEST_MAP_RESET = 18'd37448;
  localparam logic [DEST_W-1:0]     DEST_MAX       = 3'd5;

  // ceil(2^20 / 68): exact quotient for any 12-bit value
  localparam logic [13:0] NOTE_RECIP = 14'd15421;
  localparam int          NOTE_SHIFT = 20;

  typedef struct packed {
    logic                 tick;
    logic                 toggle;
    logic [BIT_SEL_W-1:0] bit_sel;
  } ring_ctrl_t;

  typedef struct packed {
    logic                 hit;
    logic [PATTERN_W-1:0] pattern_next;
  } ring_stat_t;

  // (cv / 68) mod 12; quotient is at most 60
  function automatic logic [PITCH_W-1:0] pitch_class_of(input logic [CV_W-1:0] cv);
    logic [25:0] prod;
    logic [5:0]  q;
    prod = 26'(cv) * 26'(NOTE_RECIP);
    q    = prod[25:NOTE_SHIFT];
    if (q >= 6'd48) q = q - 6'd48;
    if (q >= 6'd24) q = q - 6'd24;
    if (q >= 6'd12) q = q - 6'd12;
    return PITCH_W'(q);
  endfunction

endpackage

[rtl/rss_ring.sv]
// ----------------------------------------------------------------------------
// rss_ring
// One ring: play position and step pattern, advance with wrap and toggle.
// ----------------------------------------------------------------------------
module rss_ring #(
  parameter int MAX_STEPS = rss_pkg::MAX_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [$clog2(MAX_STEPS+1)-1:0]       count,
  input  rss_pkg::ring_ctrl_t                  ctrl,
  output logic [$clog2(MAX_STEPS)-1:0]         pos,
  output rss_pkg::ring_stat_t                  stat
);
  import rss_pkg::*;

  localparam int POS_W = $clog2(MAX_STEPS);
  localparam int CNT_W = $clog2(MAX_STEPS + 1);

  logic [PATTERN_W-1:0] pattern;
  logic [CNT_W-1:0]     pos_inc;
  logic [POS_W-1:0]     pos_next;

  assign pos_inc  = CNT_W'(pos) + CNT_W'(1);
  assign pos_next = (pos_inc >= count) ? '0 : POS_W'(pos_inc);

  assign stat.hit          = pattern[BIT_SEL_W'(pos_next)];
  assign stat.pattern_next = ctrl.toggle ?
                             (pattern ^ (PATTERN_W'(1) << ctrl.bit_sel)) : pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pattern <= '1;
    end else begin
      if (ctrl.tick) begin
        pos <= pos_next;
      end
      if (ctrl.toggle) begin
        pattern <= stat.pattern_next;
      end
    end
  end

endmodule

[rtl/ring_step_sequencer.sv]
// ----------------------------------------------------------------------------
// ring_step_sequencer
// Multi-ring step sequencer with edit cursor and CV table.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the result side stalls, and returns
// exactly one result per transaction. The input register takes an accepted
// transaction and the result register loads its result once the result
// side is free. A stalled result holds the next item in the input register;
// the input side stalls only while both registers are full. All state of an
// item (ring position, pattern bit, cursor, CV entry) is read and written in
// a single pass between those two registers, so back-to-back items see each
// other's updates. Reset clears the CV table and ring positions and sets all
// patterns to ones at once; there is no start-up sweep. Configuration writes
// are always accepted.
module ring_step_sequencer #(
  parameter int MAX_STEPS      = rss_pkg::MAX_STEPS_DEF,
  parameter int NUM_SIDES      = rss_pkg::NUM_SIDES_DEF,
  parameter int RINGS_PER_SIDE = rss_pkg::RINGS_PER_SIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // side, ring, direction, cv_index, cv_data
  input  logic [rss_pkg::IN_DATA_W-1:0]    s_tdata,
  // func
  input  logic [rss_pkg::FUNC_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // trigger_valid, trigger_dest, cv_valid, cv_out, pitch_class,
  // cursor_side, cursor_ring, cursor_step, cursor_on
  output logic [rss_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rss_pkg::*;

  localparam int NUM_RINGS = NUM_SIDES * RINGS_PER_SIDE;
  localparam int K_W       = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int POS_W     = $clog2(MAX_STEPS);
  localparam int STEP_W    = POS_W;
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);
  localparam int SIDE_W    = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;
  localparam int RING_W    = (RINGS_PER_SIDE > 1) ? $clog2(RINGS_PER_SIDE) : 1;

  // configuration
  logic [STEPS_REG_W-1:0] steps_reg [NUM_STEP_REGS];
  logic [CFG_DATA_W-1:0]  dest_map;

  // input register
  logic                  in_valid;
  logic [FUNC_W-1:0]     in_func;
  logic                  in_side;
  logic [1:0]            in_ring;
  logic                  in_dir;
  logic [CV_ADDR_W-1:0]  in_cvi;
  logic [CV_W-1:0]       in_cvd;

  // edit cursor
  logic [SIDE_W-1:0] edit_side, edit_side_next;
  logic [RING_W-1:0] edit_ring, edit_ring_next;
  logic [STEP_W-1:0] edit_step, edit_step_next;

  logic [CV_W-1:0] cv_table [CV_DEPTH];

  logic       advance;
  logic       fire;
  logic       tick_ok;
  logic [K_W-1:0] tick_k;
  logic [K_W-1:0] edit_k;
  logic [K_W-1:0] edit_k_next;
  logic [CNT_W-1:0] edit_count;
  logic [CNT_W-1:0] step_inc;

  logic [CNT_W-1:0]  lane_count [NUM_RINGS];
  logic [DEST_W-1:0] lane_dest  [NUM_RINGS];
  logic [POS_W-1:0]  lane_pos   [NUM_RINGS];
  ring_ctrl_t        lane_ctrl  [NUM_RINGS];
  ring_stat_t        lane_stat  [NUM_RINGS];

  logic                 trig;
  logic [DEST_W-1:0]    trig_dest;
  logic [PATTERN_W-1:0] cursor_pattern;
  logic                 cv_hit;
  logic [CV_W-1:0]      cv_rd;

  // result register
  logic                 out_trig;
  logic [DEST_W-1:0]    out_dest;
  logic                 out_cvv;
  logic [CV_W-1:0]      out_cv;
  logic [PITCH_W-1:0]   out_pitch;
  logic                 out_side;
  logic [1:0]           out_ring;
  logic [4:0]           out_step;
  logic                 out_on;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [STEPS_REG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) r = CNT_W'(1);
    else if (32'(c) > MAX_STEPS) r = CNT_W'(MAX_STEPS);
    else r = CNT_W'(c);
    return r;
  endfunction

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STEP_REGS; i++) begin
        steps_reg[i] <= STEPS_RESET[i];
      end
      dest_map <= DEST_MAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        [REG_STEPS0:REG_STEPS5]: steps_reg[cfg_index] <= cfg_data[STEPS_REG_W-1:0];
        REG_DEST:                dest_map <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_side <= s_tdata[0];
      in_ring <= s_tdata[2:1];
      in_dir  <= s_tdata[3];
      in_cvi  <= s_tdata[8:4];
      in_cvd  <= s_tdata[20:9];
    end
  end

  // ---------------- decode ----------------
  assign tick_ok = in_valid && (in_func == FN_TICK) &&
                   (32'(in_side) < NUM_SIDES) && (32'(in_ring) < RINGS_PER_SIDE);
  assign tick_k  = K_W'(32'(in_side) * RINGS_PER_SIDE + 32'(in_ring));
  assign edit_k  = K_W'(32'(edit_side) * RINGS_PER_SIDE + 32'(edit_ring));
  assign edit_k_next = K_W'(32'(edit_side_next) * RINGS_PER_SIDE + 32'(edit_ring_next));

  assign edit_count = lane_count[edit_k];
  assign step_inc   = CNT_W'(edit_step) + CNT_W'(1);

  always_comb begin
    edit_side_next = edit_side;
    edit_ring_next = edit_ring;
    edit_step_next = edit_step;
    if (in_valid) begin
      unique case (in_func)
        FN_STEP: begin
          if (!in_dir) begin
            edit_step_next = (step_inc >= edit_count) ? '0 : STEP_W'(step_inc);
          end else begin
            edit_step_next = (edit_step == '0) ? STEP_W'(edit_count - CNT_W'(1))
                                               : edit_step - STEP_W'(1);
          end
        end
        FN_RING: begin
          if (!in_dir) begin
            edit_ring_next = (32'(edit_ring) + 1 >= RINGS_PER_SIDE) ? '0
                             : edit_ring + RING_W'(1);
          end else begin
            edit_ring_next = (edit_ring == '0) ? RING_W'(RINGS_PER_SIDE - 1)
                             : edit_ring - RING_W'(1);
          end
          edit_step_next = '0;
        end
        FN_SIDE: begin
          edit_side_next = (32'(edit_side) + 1 >= NUM_SIDES) ? '0
                           : edit_side + SIDE_W'(1);
          edit_step_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edit_side <= '0;
      edit_ring <= '0;
      edit_step <= '0;
    end else if (fire) begin
      edit_side <= edit_side_next;
      edit_ring <= edit_ring_next;
      edit_step <= edit_step_next;
    end
  end

  // ---------------- rings ----------------
  for (genvar i = 0; i < NUM_RINGS; i++) begin : g_ring
    if (i < NUM_STEP_REGS) begin : g_reg
      logic [DEST_W-1:0] d;
      assign d             = dest_map[DEST_W*i +: DEST_W];
      assign lane_count[i] = clamp_count(steps_reg[i]);
      assign lane_dest[i]  = (d > DEST_MAX) ? DEST_MAX : d;
    end else begin : g_noreg
      assign lane_count[i] = CNT_W'(MAX_STEPS);
      assign lane_dest[i]  = '0;
    end

    assign lane_ctrl[i].tick    = fire && tick_ok && (tick_k == K_W'(i));
    assign lane_ctrl[i].toggle  = fire && (in_func == FN_TOGGLE) && (edit_k == K_W'(i));
    assign lane_ctrl[i].bit_sel = BIT_SEL_W'(edit_step);

    rss_ring #(
      .MAX_STEPS (MAX_STEPS)
    ) u_ring (
      .clk   (clk),
      .rst   (rst),
      .count (lane_count[i]),
      .ctrl  (lane_ctrl[i]),
      .pos   (lane_pos[i]),
      .stat  (lane_stat[i])
    );
  end

  always_comb begin
    trig           = 1'b0;
    trig_dest      = '0;
    cursor_pattern = '0;
    for (int i = 0; i < NUM_RINGS; i++) begin
      if (tick_ok && (tick_k == K_W'(i)) && lane_stat[i].hit) begin
        trig      = 1'b1;
        trig_dest = trig_dest | lane_dest[i];
      end
      if (edit_k_next == K_W'(i)) begin
        cursor_pattern = cursor_pattern | lane_stat[i].pattern_next;
      end
    end
  end

  // ---------------- CV table ----------------
  assign cv_hit = tick_ok && (tick_k == '0);
  assign cv_rd  = cv_table[CV_ADDR_W'(lane_pos[0])];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CV_DEPTH; i++) begin
        cv_table[i] <= '0;
      end
    end else if (fire && (in_func == FN_CV)) begin
      cv_table[in_cvi] <= in_cvd;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_trig  <= trig;
      out_dest  <= trig_dest;
      out_cvv   <= cv_hit;
      out_cv    <= cv_hit ? cv_rd : '0;
      out_pitch <= cv_hit ? pitch_class_of(cv_rd) : '0;
      out_side  <= edit_side_next[0];
      out_ring  <= 2'(edit_ring_next);
      out_step  <= 5'(edit_step_next);
      out_on    <= cursor_pattern[BIT_SEL_W'(edit_step_next)];
    end
  end

  assign m_tdata = {2'b00, out_on, out_step, out_ring, out_side, out_pitch,
                    out_cv, out_cvv, out_dest, out_trig};

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for ring_step_sequencer. A directed table is run first, with
// some results typed in by hand. Random phases follow, each with its own
// set of step counts and destinations. A local copy of the sequencer state
// predicts every result, and results are compared field by field in order.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam int NUM_RINGS       = NUM_SIDES_DEF * RINGS_PER_SIDE_DEF;
  localparam int PITCH_DIV       = 68;
  localparam int PITCH_MOD       = 12;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 193;
  localparam int NUM_DIRECTED    = 22;

  // codes the block leaves unused
  localparam logic [FUNC_W-1:0] FN_UNUSED6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED7 = 3'd7;

  // input fields, lowest bit first from the bottom of the struct
  typedef struct packed {
    logic [CV_W-1:0]      cv_data;
    logic [CV_ADDR_W-1:0] cv_index;
    logic                 dir;
    logic [1:0]           ring;
    logic                 side;
  } edit_fields_t;

  typedef struct packed {
    logic              trig;
    logic [DEST_W-1:0] dest;
    logic              cv_v;
    logic [CV_W-1:0]   cv;
    logic [PITCH_W-1:0] pitch;
    logic              side;
    logic [1:0]        ring;
    logic [4:0]        step;
    logic              on;
  } seq_result_t;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic                 side;
    logic [1:0]           ring;
    logic                 dir;
    logic [CV_ADDR_W-1:0] cvi;
    logic [CV_W-1:0]      cvd;
    logic                 chk;
    seq_result_t          want;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic [FUNC_W-1:0]      s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // sequencer state as predicted
  logic [STEPS_REG_W-1:0] steps_cfg [NUM_STEP_REGS];
  logic [CFG_DATA_W-1:0]  dest_cfg;
  logic [PATTERN_W-1:0]   patterns [NUM_RINGS];
  logic [4:0]             ring_pos [NUM_RINGS];
  logic [CV_W-1:0]        cv_tab [CV_DEPTH];
  int                     cur_side;
  int                     cur_ring;
  int                     cur_step;

  seq_result_t            pending_results [$];
  int                     mismatch_count;
  bit                     no_idle;

  // after reset: tick, CV loads, dead rings, toggles, cursor moves, unused codes
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{FN_TICK,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b1, 3'd0, 1'b1, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_CV,      1'b0, 2'd0, 1'b0, 5'd1,  12'd4095, 1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TICK,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b1, 3'd0, 1'b1, 12'd4095, 4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_CV,      1'b1, 2'd3, 1'b1, 5'd2,  12'd2048, 1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TICK,    1'b0, 2'd0, 1'b1, 5'd31, 12'd4095, 1'b1,
      '{1'b1, 3'd0, 1'b1, 12'd2048, 4'd6, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TICK,    1'b1, 2'd2, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b1, 3'd1, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TICK,    1'b1, 2'd3, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TICK,    1'b0, 2'd3, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b1}},
    '{FN_TOGGLE,  1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_STEP,    1'b0, 2'd0, 1'b1, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd15, 1'b1}},
    '{FN_STEP,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_UNUSED6, 1'b1, 2'd1, 1'b1, 5'd7,  12'd77,   1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_UNUSED7, 1'b0, 2'd2, 1'b0, 5'd8,  12'd99,   1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_RING,    1'b0, 2'd0, 1'b1, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd2, 5'd0,  1'b1}},
    '{FN_RING,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_SIDE,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b1, 2'd0, 5'd0,  1'b1}},
    '{FN_SIDE,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b1,
      '{1'b0, 3'd0, 1'b0, 12'd0,    4'd0, 1'b0, 2'd0, 5'd0,  1'b0}},
    '{FN_CV,      1'b0, 2'd0, 1'b0, 5'd31, 12'hAAA,  1'b0, '0},
    '{FN_CV,      1'b0, 2'd0, 1'b1, 5'd3,  12'h555,  1'b0, '0},
    '{FN_TICK,    1'b0, 2'd0, 1'b0, 5'd0,  12'd0,    1'b0, '0},
    '{FN_TOGGLE,  1'b1, 2'd1, 1'b0, 5'd0,  12'd0,    1'b0, '0},
    '{FN_TICK,    1'b1, 2'd0, 1'b1, 5'd0,  12'd0,    1'b0, '0}
  };

  ring_step_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("[ring_step_sequencer] ERROR");
    $finish;
  end

  function automatic int ring_len(int k);
    int c;
    c = steps_cfg[k];
    if (c < 1) c = 1;
    if (c > MAX_STEPS_DEF) c = MAX_STEPS_DEF;
    return c;
  endfunction

  function automatic logic [DEST_W-1:0] ring_dest(int k);
    logic [DEST_W-1:0] d;
    d = dest_cfg[3*k +: 3];
    if (d > DEST_MAX) d = DEST_MAX;
    return d;
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_STEP_REGS; i++) steps_cfg[i] = STEPS_RESET[i];
    dest_cfg = DEST_MAP_RESET;
    for (int i = 0; i < NUM_RINGS; i++) begin
      patterns[i] = '1;
      ring_pos[i] = '0;
    end
    for (int i = 0; i < CV_DEPTH; i++) cv_tab[i] = '0;
    cur_side = 0;
    cur_ring = 0;
    cur_step = 0;
  endtask

  // applies one item to the local state, returns the result it must produce
  function automatic seq_result_t advance_sequencer(logic [FUNC_W-1:0] func,
                                                    edit_fields_t f);
    seq_result_t r;
    int k;
    int p;
    int cnt;
    r = '0;
    case (func)
      FN_TICK: begin
        if (f.side < NUM_SIDES_DEF && f.ring < RINGS_PER_SIDE_DEF) begin
          k = f.side * RINGS_PER_SIDE_DEF + f.ring;
          p = ring_pos[k];
          if (k == 0) begin
            r.cv_v  = 1'b1;
            r.cv    = cv_tab[p];
            r.pitch = PITCH_W'((r.cv / PITCH_DIV) % PITCH_MOD);
          end
          p = p + 1;
          if (p >= ring_len(k)) p = 0;
          ring_pos[k] = 5'(p);
          if (patterns[k][p]) begin
            r.trig = 1'b1;
            r.dest = ring_dest(k);
          end
        end
      end
      FN_STEP: begin
        cnt = ring_len(cur_side * RINGS_PER_SIDE_DEF + cur_ring);
        if (!f.dir) cur_step = (cur_step + 1 >= cnt) ? 0 : cur_step + 1;
        else cur_step = (cur_step == 0) ? cnt - 1 : cur_step - 1;
      end
      FN_RING: begin
        if (!f.dir) cur_ring = (cur_ring + 1 >= RINGS_PER_SIDE_DEF) ? 0 : cur_ring + 1;
        else cur_ring = (cur_ring == 0) ? RINGS_PER_SIDE_DEF - 1 : cur_ring - 1;
        cur_step = 0;
      end
      FN_SIDE: begin
        cur_side = (cur_side + 1 >= NUM_SIDES_DEF) ? 0 : cur_side + 1;
        cur_step = 0;
      end
      FN_TOGGLE: begin
        k = cur_side * RINGS_PER_SIDE_DEF + cur_ring;
        patterns[k][cur_step] = ~patterns[k][cur_step];
      end
      FN_CV: cv_tab[f.cv_index] = f.cv_data;
      default: ;
    endcase
    k = cur_side * RINGS_PER_SIDE_DEF + cur_ring;
    r.side = cur_side[0];
    r.ring = cur_ring[1:0];
    r.step = cur_step[4:0];
    r.on   = patterns[k][cur_step];
    return r;
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] func, edit_fields_t f, logic chk,
                           seq_result_t typed);
    int gap;
    seq_result_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= IN_DATA_W'(f);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = advance_sequencer(func, f);
    pending_results.push_back(chk ? typed : pred);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= REG_STEPS5) steps_cfg[idx] = val[STEPS_REG_W-1:0];
    else if (idx == REG_DEST) dest_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_phase(int ph);
    logic [STEPS_REG_W-1:0] cnt;
    logic [CFG_DATA_W-1:0]  dmap;
    for (int i = 0; i < NUM_STEP_REGS; i++) begin
      case (ph)
        1: cnt = 6'd1;
        2: cnt = 6'd32;
        3: cnt = (i % 2) ? 6'd63 : 6'd0;
        4: cnt = (i % 2) ? 6'd2 : 6'd33;
        default: cnt = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(1, 8))
                                                     : 6'($urandom_range(0, 63));
      endcase
      write_reg(REG_STEPS0 + CFG_IDX_W'(i), {12'($urandom), cnt});
    end
    case (ph)
      1: dmap = '1;
      2: dmap = '0;
      default: dmap = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_DEST, dmap);
  endtask

  task automatic draw_item(int focus, output logic [FUNC_W-1:0] func,
                           output edit_fields_t f);
    int sel;
    sel = $urandom_range(0, 99);
    f.side     = 1'($urandom_range(0, 1));
    f.ring     = 2'($urandom_range(0, 3));
    f.dir      = 1'($urandom_range(0, 1));
    f.cv_index = CV_ADDR_W'($urandom_range(0, CV_DEPTH - 1));
    f.cv_data  = CV_W'($urandom_range(0, 4095));
    if (sel < 50) begin
      func = FN_TICK;
      if ($urandom_range(0, 9) < 6) begin
        f.side = 1'(focus / RINGS_PER_SIDE_DEF);
        f.ring = 2'(focus % RINGS_PER_SIDE_DEF);
      end
    end else if (sel < 62) func = FN_STEP;
    else if (sel < 70) func = FN_RING;
    else if (sel < 75) func = FN_SIDE;
    else if (sel < 87) func = FN_TOGGLE;
    else if (sel < 97) func = FN_CV;
    else func = sel[0] ? FN_UNUSED7 : FN_UNUSED6;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] w);
    seq_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result %h with nothing expected", $time, w);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("trigger_valid", want.trig,  w[0]);
      check_field("trigger_dest",  want.dest,  w[3:1]);
      check_field("cv_valid",      want.cv_v,  w[4]);
      check_field("cv_out",        want.cv,    w[16:5]);
      check_field("pitch_class",   want.pitch, w[20:17]);
      check_field("cursor_side",   want.side,  w[21]);
      check_field("cursor_ring",   want.ring,  w[23:22]);
      check_field("cursor_step",   want.step,  w[28:24]);
      check_field("cursor_on",     want.on,    w[29]);
    end
  endtask

  // result side
  initial begin
    int stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_result(m_tdata);
    end
  end

  initial begin
    logic [FUNC_W-1:0] func;
    edit_fields_t      f;
    int                focus;
    mismatch_count = 0;
    no_idle        = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= FN_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_STEPS0;
    cfg_data  <= '0;
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      f.side     = directed_rows[i].side;
      f.ring     = directed_rows[i].ring;
      f.dir      = directed_rows[i].dir;
      f.cv_index = directed_rows[i].cvi;
      f.cv_data  = directed_rows[i].cvd;
      send_item(directed_rows[i].func, f, directed_rows[i].chk, directed_rows[i].want);
    end

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      drain();
      program_phase(ph);
      no_idle = (ph % 4 == 3);
      focus   = $urandom_range(0, NUM_RINGS - 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        draw_item(focus, func, f);
        send_item(func, f, 1'b0, '0);
      end
    end
    drain();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ring_step_sequencer] OK");
    end else begin
      $display("[ring_step_sequencer] ERROR");
    end
    $finish;
  end

endmodule
